// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge, also while reset is held.
`define RWP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

// Check only outside reset.
`define RWP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`endif

// File: src/rwp_pkg.sv
`default_nettype none

package rwp_pkg;

  localparam logic [31:0] ID_RIFF = 32'h4646_4952;
  localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_SIZE_EXT = 32'd18;
  localparam logic [31:0] FMT_SIZE_STD = 32'd16;

  typedef enum logic [2:0] {
    PH_ID,
    PH_RIFF,
    PH_FMT,
    PH_SKIPSIZE,
    PH_SKIP,
    PH_DATASIZE,
    PH_SAMPLES,
    PH_DONE
  } rwp_phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_ERROR  = 2'd2
  } rwp_kind_e;

  typedef struct packed {
    rwp_kind_e   result_kind;
    logic [15:0] channel_index;
    logic [31:0] sample_value;
    logic [15:0] format_code;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] bit_depth;
    logic [31:0] data_size;
    logic [31:0] riff_size;
  } rwp_result_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       start_of_stream;
  } rwp_word_t;

endpackage

`default_nettype wire

// File: src/riff_wave_stream_parser_core.sv
// Channel | Direction | Handshake            | Word
// in      | input     | in_valid_i/in_stall_o | byte_value_i, start_of_stream_i
// out     | output    | out_valid_o/out_stall_i | result_kind_o .. riff_size_o
//
// One byte is accepted per cycle, back to back, while in_stall_o is low.
// An accepted byte reaches its result through the input register and then the result register.
// A byte gives at most one result; a byte without a result leaves the result register empty.
// Reset clears parse state and both valid flags; the parser then awaits a chunk id.
// out_stall_i holds the result register and stalls the input register behind it.
`default_nettype none

module riff_wave_stream_parser_core
  import rwp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  byte_value_i,
  input  wire logic        start_of_stream_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       result_kind_o,
  output logic [15:0]      channel_index_o,
  output logic [31:0]      sample_value_o,
  output logic [15:0]      format_code_o,
  output logic [15:0]      channel_count_o,
  output logic [31:0]      sample_rate_o,
  output logic [31:0]      byte_rate_o,
  output logic [15:0]      block_align_o,
  output logic [15:0]      bit_depth_o,
  output logic [31:0]      data_size_o,
  output logic [31:0]      riff_size_o
);

  rwp_word_t   in_word;
  rwp_word_t   stage_word;
  logic        stage_valid;
  logic        out_ready;
  logic        step;
  logic        res_valid;
  rwp_result_t res;
  rwp_result_t out_res;

  assign in_word.byte_value      = byte_value_i;
  assign in_word.start_of_stream = start_of_stream_i;
  assign step                    = stage_valid && out_ready;

  rwp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .word_i     (in_word),
    .advance_i  (out_ready),
    .valid_o    (stage_valid),
    .word_o     (stage_word)
  );

  rwp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .word_i      (stage_word),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  rwp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && res_valid),
    .res_i       (res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign result_kind_o   = out_res.result_kind;
  assign channel_index_o = out_res.channel_index;
  assign sample_value_o  = out_res.sample_value;
  assign format_code_o   = out_res.format_code;
  assign channel_count_o = out_res.channel_count;
  assign sample_rate_o   = out_res.sample_rate;
  assign byte_rate_o     = out_res.byte_rate;
  assign block_align_o   = out_res.block_align;
  assign bit_depth_o     = out_res.bit_depth;
  assign data_size_o     = out_res.data_size;
  assign riff_size_o     = out_res.riff_size;

endmodule

`default_nettype wire

// File: src/rwp_in_reg.sv
`default_nettype none

module rwp_in_reg
  import rwp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire rwp_word_t word_i,
  input  wire logic      advance_i,
  output logic           valid_o,
  output rwp_word_t      word_o
);

  logic      valid_q;
  rwp_word_t word_q;

  assign in_stall_o = valid_q && !advance_i;
  assign valid_o    = valid_q;
  assign word_o     = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      word_q <= word_i;
    end
  end

endmodule

`default_nettype wire

// File: src/rwp_parse.sv
`default_nettype none

module rwp_parse
  import rwp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      step_i,
  input  wire rwp_word_t word_i,
  output logic           res_valid_o,
  output rwp_result_t    res_o
);

  rwp_phase_e  phase_q, phase_d, cur_phase;
  logic [31:0] shift_q, shift_d, cur_shift;
  logic [4:0]  fpos_q, fpos_d, cur_fpos, fpos_inc;
  logic [31:0] skip_q, skip_d, cur_skip;
  logic [31:0] rem_q, rem_d, cur_rem;
  logic [31:0] fmt_q, fmt_d, cur_fmt;
  logic [15:0] format_q, format_d, cur_format;
  logic [15:0] chans_q, chans_d, cur_chans;
  logic [31:0] rate_q, rate_d, cur_rate;
  logic [31:0] brate_q, brate_d, cur_brate;
  logic [15:0] align_q, align_d, cur_align;
  logic [15:0] depth_q, depth_d, cur_depth;
  logic [31:0] riff_q, riff_d, cur_riff;
  logic [31:0] dsize_q, dsize_d, cur_dsize;
  logic [1:0]  sbi_q, sbi_d, cur_sbi;
  logic [15:0] chan_q, chan_d, cur_chan;

  logic [31:0] bs;
  logic [15:0] w16;
  logic [12:0] bps;
  logic        bps_ok;
  logic [17:0] frame;
  logic [1:0]  last_idx;
  logic [16:0] chan_inc;
  logic        has_res;
  rwp_kind_e   res_kind;
  logic [15:0] res_chan;
  logic [31:0] res_val;

  always_comb begin
    cur_phase  = word_i.start_of_stream ? PH_ID : phase_q;
    cur_shift  = word_i.start_of_stream ? '0 : shift_q;
    cur_fpos   = word_i.start_of_stream ? '0 : fpos_q;
    cur_skip   = word_i.start_of_stream ? '0 : skip_q;
    cur_rem    = word_i.start_of_stream ? '0 : rem_q;
    cur_fmt    = word_i.start_of_stream ? '0 : fmt_q;
    cur_format = word_i.start_of_stream ? '0 : format_q;
    cur_chans  = word_i.start_of_stream ? '0 : chans_q;
    cur_rate   = word_i.start_of_stream ? '0 : rate_q;
    cur_brate  = word_i.start_of_stream ? '0 : brate_q;
    cur_align  = word_i.start_of_stream ? '0 : align_q;
    cur_depth  = word_i.start_of_stream ? '0 : depth_q;
    cur_riff   = word_i.start_of_stream ? '0 : riff_q;
    cur_dsize  = word_i.start_of_stream ? '0 : dsize_q;
    cur_sbi    = word_i.start_of_stream ? '0 : sbi_q;
    cur_chan   = word_i.start_of_stream ? '0 : chan_q;

    bs       = {word_i.byte_value, cur_shift[31:8]};
    w16      = bs[31:16];
    fpos_inc = cur_fpos + 5'd1;
    bps      = cur_depth[15:3];
    bps_ok   = (bps == 13'd1) || (bps == 13'd2) || (bps == 13'd4);
    if (bps == 13'd4) begin
      frame    = {cur_chans, 2'b00};
      last_idx = 2'd3;
    end else if (bps == 13'd2) begin
      frame    = {1'b0, cur_chans, 1'b0};
      last_idx = 2'd1;
    end else begin
      frame    = {2'b00, cur_chans};
      last_idx = 2'd0;
    end
    chan_inc = {1'b0, cur_chan} + 17'd1;

    phase_d  = cur_phase;
    shift_d  = bs;
    fpos_d   = cur_fpos;
    skip_d   = cur_skip;
    rem_d    = cur_rem;
    fmt_d    = cur_fmt;
    format_d = cur_format;
    chans_d  = cur_chans;
    rate_d   = cur_rate;
    brate_d  = cur_brate;
    align_d  = cur_align;
    depth_d  = cur_depth;
    riff_d   = cur_riff;
    dsize_d  = cur_dsize;
    sbi_d    = cur_sbi;
    chan_d   = cur_chan;
    has_res  = 1'b0;
    res_kind = KIND_HEADER;
    res_chan = '0;
    res_val  = '0;

    case (cur_phase)
      PH_ID: begin
        fpos_d = fpos_inc;
        if (cur_fpos >= 5'd3) begin
          fpos_d = '0;
          if (bs == ID_RIFF) begin
            phase_d = PH_RIFF;
          end else if (bs == ID_FMT) begin
            phase_d = PH_FMT;
          end else if (bs == ID_DATA) begin
            phase_d = PH_DATASIZE;
          end else begin
            phase_d = PH_SKIPSIZE;
          end
        end
      end
      PH_RIFF: begin
        fpos_d = fpos_inc;
        if (cur_fpos == 5'd3) begin
          riff_d = bs;
        end
        if (cur_fpos >= 5'd7) begin
          fpos_d  = '0;
          phase_d = PH_ID;
        end
      end
      PH_FMT: begin
        fpos_d = fpos_inc;
        case (cur_fpos)
          5'd3:  fmt_d    = bs;
          5'd5:  format_d = w16;
          5'd7:  chans_d  = w16;
          5'd11: rate_d   = bs;
          5'd15: brate_d  = bs;
          5'd17: align_d  = w16;
          5'd19: begin
            depth_d = w16;
            if (cur_fmt == FMT_SIZE_EXT) begin
              fpos_d = fpos_inc;
            end else if (cur_fmt > FMT_SIZE_STD) begin
              skip_d  = cur_fmt - FMT_SIZE_STD;
              fpos_d  = '0;
              phase_d = (skip_d == '0) ? PH_ID : PH_SKIP;
            end else begin
              fpos_d  = '0;
              phase_d = PH_ID;
            end
          end
          5'd21: begin
            skip_d  = {16'd0, w16};
            fpos_d  = '0;
            phase_d = (w16 == '0) ? PH_ID : PH_SKIP;
          end
          default: fpos_d = fpos_inc;
        endcase
      end
      PH_SKIPSIZE: begin
        fpos_d = fpos_inc;
        if (cur_fpos >= 5'd3) begin
          skip_d  = bs;
          fpos_d  = '0;
          phase_d = (bs == '0) ? PH_ID : PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_d = cur_skip - 32'd1;
        if (skip_d == '0) begin
          fpos_d  = '0;
          phase_d = PH_ID;
        end
      end
      PH_DATASIZE: begin
        fpos_d = fpos_inc;
        if (cur_fpos >= 5'd3) begin
          fpos_d  = '0;
          dsize_d = bs;
          has_res = 1'b1;
          if (!bps_ok || cur_chans == '0) begin
            phase_d  = PH_DONE;
            res_kind = KIND_ERROR;
          end else begin
            rem_d    = bs;
            sbi_d    = '0;
            chan_d   = '0;
            phase_d  = PH_SAMPLES;
            res_kind = KIND_HEADER;
          end
        end
      end
      PH_SAMPLES: begin
        // stop at the first frame that the remaining bytes cannot fill
        if (cur_sbi == '0 && cur_chan == '0 && cur_rem < {14'd0, frame}) begin
          phase_d = PH_DONE;
        end else begin
          rem_d = cur_rem - 32'd1;
          if (cur_sbi != last_idx) begin
            sbi_d = cur_sbi + 2'd1;
          end else begin
            sbi_d    = '0;
            has_res  = 1'b1;
            res_kind = KIND_SAMPLE;
            res_chan = cur_chan;
            chan_d   = (chan_inc >= {1'b0, cur_chans}) ? '0 : chan_inc[15:0];
            if (bps == 13'd4) begin
              res_val = bs;
            end else if (bps == 13'd2) begin
              res_val = {16'd0, bs[31:16]};
            end else begin
              res_val = {24'd0, bs[31:24]};
            end
          end
        end
      end
      default: begin
        phase_d = cur_phase;
      end
    endcase
  end

  assign res_valid_o         = has_res;
  assign res_o.result_kind   = res_kind;
  assign res_o.channel_index = res_chan;
  assign res_o.sample_value  = res_val;
  assign res_o.format_code   = format_d;
  assign res_o.channel_count = chans_d;
  assign res_o.sample_rate   = rate_d;
  assign res_o.byte_rate     = brate_d;
  assign res_o.block_align   = align_d;
  assign res_o.bit_depth     = depth_d;
  assign res_o.data_size     = dsize_d;
  assign res_o.riff_size     = riff_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_ID;
      shift_q  <= '0;
      fpos_q   <= '0;
      skip_q   <= '0;
      rem_q    <= '0;
      fmt_q    <= '0;
      format_q <= '0;
      chans_q  <= '0;
      rate_q   <= '0;
      brate_q  <= '0;
      align_q  <= '0;
      depth_q  <= '0;
      riff_q   <= '0;
      dsize_q  <= '0;
      sbi_q    <= '0;
      chan_q   <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      shift_q  <= shift_d;
      fpos_q   <= fpos_d;
      skip_q   <= skip_d;
      rem_q    <= rem_d;
      fmt_q    <= fmt_d;
      format_q <= format_d;
      chans_q  <= chans_d;
      rate_q   <= rate_d;
      brate_q  <= brate_d;
      align_q  <= align_d;
      depth_q  <= depth_d;
      riff_q   <= riff_d;
      dsize_q  <= dsize_d;
      sbi_q    <= sbi_d;
      chan_q   <= chan_d;
    end
  end

endmodule

`default_nettype wire

// File: src/rwp_out_reg.sv
`default_nettype none

module rwp_out_reg
  import rwp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire rwp_result_t res_i,
  output logic             ready_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output rwp_result_t      res_o
);

  logic        valid_q;
  rwp_result_t res_q;

  assign ready_o     = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

// File: src/rwp_checker.sv
`default_nettype none

`include "assert_macros.svh"

module rwp_checker
  import rwp_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  result_kind_o,
  input wire logic [15:0] channel_index_o,
  input wire logic [31:0] sample_value_o,
  input wire logic [15:0] channel_count_o,
  input wire logic [15:0] bit_depth_o
);

  logic [12:0] bps;
  logic        held;
  logic [33:0] out_key;
  logic        is_sample;
  logic        is_error;
  logic        byte_wide;
  logic        layout_ok;

  assign bps       = bit_depth_o[15:3];
  assign held      = out_valid_o && out_stall_i;
  assign out_key   = {result_kind_o, sample_value_o};
  assign is_sample = out_valid_o && result_kind_o == KIND_SAMPLE;
  assign is_error  = out_valid_o && result_kind_o == KIND_ERROR;
  assign byte_wide = sample_value_o[31:8] != 24'd0;
  assign layout_ok = channel_count_o != 16'd0
                     && (bps == 13'd1 || bps == 13'd2 || bps == 13'd4);

  `RWP_ASSERT_ALWAYS(a_no_word_in_reset, !rst_ni |-> !out_valid_o, "result word during reset")

  `RWP_ASSERT(a_out_hold, held |=> out_valid_o && $stable(out_key), "stalled word changed")

  `RWP_ASSERT(a_chan_range, is_sample |-> channel_index_o < channel_count_o, "channel out of range")

  `RWP_ASSERT(a_byte_sample, is_sample && bps == 13'd1 |-> !byte_wide, "byte sample too wide")

  `RWP_ASSERT(a_error_layout, is_error |-> !layout_ok, "error on a supported layout")

endmodule

bind riff_wave_stream_parser_core rwp_checker u_rwp_checker (.*);

`default_nettype wire

// File: dv/riff_wave_stream_parser_core_tb.sv
`timescale 1ns / 100ps

module riff_wave_stream_parser_core_tb;
  import rwp_pkg::*;

  localparam logic [31:0] ID_WAVE = 32'h4556_4157;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  byte_value_i;
  logic        start_of_stream_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  result_kind_o;
  logic [15:0] channel_index_o;
  logic [31:0] sample_value_o;
  logic [15:0] format_code_o;
  logic [15:0] channel_count_o;
  logic [31:0] sample_rate_o;
  logic [31:0] byte_rate_o;
  logic [15:0] block_align_o;
  logic [15:0] bit_depth_o;
  logic [31:0] data_size_o;
  logic [31:0] riff_size_o;

  riff_wave_stream_parser_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .byte_value_i      (byte_value_i),
    .start_of_stream_i (start_of_stream_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .result_kind_o     (result_kind_o),
    .channel_index_o   (channel_index_o),
    .sample_value_o    (sample_value_o),
    .format_code_o     (format_code_o),
    .channel_count_o   (channel_count_o),
    .sample_rate_o     (sample_rate_o),
    .byte_rate_o       (byte_rate_o),
    .block_align_o     (block_align_o),
    .bit_depth_o       (bit_depth_o),
    .data_size_o       (data_size_o),
    .riff_size_o       (riff_size_o)
  );

  // parser shadow state
  rwp_phase_e  phase;
  logic [31:0] shift_reg;
  logic [7:0]  fpos;
  logic [31:0] skip_cnt;
  logic [31:0] data_left;
  logic [31:0] fmt_len;
  logic [15:0] fmt_tag;
  logic [15:0] chans;
  logic [31:0] rate;
  logic [31:0] byte_rate;
  logic [15:0] align;
  logic [15:0] depth;
  logic [31:0] riff_len;
  logic [31:0] data_len;
  logic [1:0]  byte_idx;
  logic [15:0] cur_ch;

  rwp_result_t predicted_results[$];
  rwp_result_t want;
  logic [7:0]  file_bytes[$];
  int          mismatch_count;
  int          words_sent;
  int          burst_left;
  int          stall_cycle;
  int          stall_mode;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic void clear_parser();
    phase     = PH_ID;
    shift_reg = '0;
    fpos      = '0;
    skip_cnt  = '0;
    data_left = '0;
    fmt_len   = '0;
    fmt_tag   = '0;
    chans     = '0;
    rate      = '0;
    byte_rate = '0;
    align     = '0;
    depth     = '0;
    riff_len  = '0;
    data_len  = '0;
    byte_idx  = '0;
    cur_ch    = '0;
  endfunction

  function automatic void start_skip(input logic [31:0] n);
    skip_cnt = n;
    fpos     = '0;
    if (n == 0) begin
      phase = PH_ID;
    end else begin
      phase = PH_SKIP;
    end
  endfunction

  function automatic rwp_result_t make_result(input rwp_kind_e kind, input logic [15:0] ch,
                                              input logic [31:0] val);
    rwp_result_t r;
    r.result_kind   = kind;
    r.channel_index = ch;
    r.sample_value  = val;
    r.format_code   = fmt_tag;
    r.channel_count = chans;
    r.sample_rate   = rate;
    r.byte_rate     = byte_rate;
    r.block_align   = align;
    r.bit_depth     = depth;
    r.data_size     = data_len;
    r.riff_size     = riff_len;
    return r;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, input logic sos,
                                    output rwp_result_t r);
    logic [7:0]  pos;
    logic [15:0] w16;
    logic [31:0] bps;
    logic [31:0] frame;
    bit          emitted;
    emitted = 1'b0;
    r = '0;
    if (sos) clear_parser();
    shift_reg = {b, shift_reg[31:8]};
    w16 = shift_reg[31:16];
    pos = fpos;
    case (phase)
      PH_ID: begin
        fpos = pos + 8'd1;
        if (pos >= 8'd3) begin
          fpos = '0;
          if (shift_reg == ID_RIFF) phase = PH_RIFF;
          else if (shift_reg == ID_FMT) phase = PH_FMT;
          else if (shift_reg == ID_DATA) phase = PH_DATASIZE;
          else phase = PH_SKIPSIZE;
        end
      end
      PH_RIFF: begin
        fpos = pos + 8'd1;
        if (pos == 8'd3) riff_len = shift_reg;
        if (pos >= 8'd7) begin
          fpos  = '0;
          phase = PH_ID;
        end
      end
      PH_FMT: begin
        fpos = pos + 8'd1;
        case (pos)
          8'd3:  fmt_len = shift_reg;
          8'd5:  fmt_tag = w16;
          8'd7:  chans = w16;
          8'd11: rate = shift_reg;
          8'd15: byte_rate = shift_reg;
          8'd17: align = w16;
          8'd19: begin
            depth = w16;
            if (fmt_len == FMT_SIZE_EXT) begin
            end else if (fmt_len > FMT_SIZE_STD) begin
              start_skip(fmt_len - FMT_SIZE_STD);
            end else begin
              fpos  = '0;
              phase = PH_ID;
            end
          end
          8'd21: start_skip({16'h0, w16});
          default: ;
        endcase
        if (fpos > 8'd21) begin
          fpos  = '0;
          phase = PH_ID;
        end
      end
      PH_SKIPSIZE: begin
        fpos = pos + 8'd1;
        if (pos >= 8'd3) start_skip(shift_reg);
      end
      PH_SKIP: begin
        skip_cnt = skip_cnt - 32'd1;
        if (skip_cnt == 0) begin
          fpos  = '0;
          phase = PH_ID;
        end
      end
      PH_DATASIZE: begin
        fpos = pos + 8'd1;
        if (pos >= 8'd3) begin
          fpos     = '0;
          data_len = shift_reg;
          bps      = {16'h0, depth} / 32'd8;
          emitted  = 1'b1;
          if ((bps != 1 && bps != 2 && bps != 4) || chans == 0) begin
            phase = PH_DONE;
            r = make_result(KIND_ERROR, '0, '0);
          end else begin
            frame     = bps * {16'h0, chans};
            data_left = (data_len / frame) * frame;
            byte_idx  = '0;
            cur_ch    = '0;
            if (data_left == 0) begin
              phase = PH_DONE;
            end else begin
              phase = PH_SAMPLES;
            end
            r = make_result(KIND_HEADER, '0, '0);
          end
        end
      end
      PH_SAMPLES: begin
        bps = {16'h0, depth} / 32'd8;
        if (bps == 0 || bps > 4 || data_left == 0) begin
          phase = PH_DONE;
        end else begin
          data_left = data_left - 32'd1;
          if ({30'h0, byte_idx} + 32'd1 < bps) begin
            byte_idx = byte_idx + 2'd1;
          end else begin
            byte_idx = '0;
            r = make_result(KIND_SAMPLE, cur_ch, shift_reg >> (32 - 8 * bps));
            emitted = 1'b1;
            if ({16'h0, cur_ch} + 32'd1 >= {16'h0, chans}) begin
              cur_ch = '0;
            end else begin
              cur_ch = cur_ch + 16'd1;
            end
            if (data_left == 0) phase = PH_DONE;
          end
        end
      end
      default: ;
    endcase
    return emitted;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (predicted_results.size() == 0) begin
        $display("%0t mismatch unexpected word: expected none actual kind %h", $time,
                 result_kind_o);
        mismatch_count++;
      end else begin
        want = predicted_results.pop_front();
        check_field("result_kind", 32'(want.result_kind), 32'(result_kind_o));
        check_field("channel_index", 32'(want.channel_index), 32'(channel_index_o));
        check_field("sample_value", want.sample_value, sample_value_o);
        check_field("format_code", 32'(want.format_code), 32'(format_code_o));
        check_field("channel_count", 32'(want.channel_count), 32'(channel_count_o));
        check_field("sample_rate", want.sample_rate, sample_rate_o);
        check_field("byte_rate", want.byte_rate, byte_rate_o);
        check_field("block_align", 32'(want.block_align), 32'(block_align_o));
        check_field("bit_depth", 32'(want.bit_depth), 32'(bit_depth_o));
        check_field("data_size", want.data_size, data_size_o);
        check_field("riff_size", want.riff_size, riff_size_o);
      end
    end
  end

  // stall the result side in one of four modes, each picked at random
  always @(negedge clk_i) begin
    if (stall_cycle % 48 == 0) stall_mode = $urandom_range(0, 3);
    stall_cycle++;
    case (stall_mode)
      0: out_stall_i = 1'b0;
      1: out_stall_i = ($urandom_range(0, 4) == 0);
      2: out_stall_i = ($urandom_range(0, 9) < 7);
      default: out_stall_i = (stall_cycle % 3 == 0);
    endcase
  end

  task automatic send_word(input logic [7:0] b, input logic sos);
    rwp_result_t r;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
      end
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(60, 150);
      end else begin
        burst_left = $urandom_range(1, 12);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i        = 1'b1;
    byte_value_i      = b;
    start_of_stream_i = sos;
    do @(posedge clk_i); while (in_stall_o);
    if (parse_byte(b, sos, r)) predicted_results.push_back(r);
    words_sent++;
  endtask

  task automatic pause_until_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (predicted_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic void push_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(v[8 * i +: 8]);
  endfunction

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_file(input bit with_riff, input int junk_len, input int fmt_size,
                           input int ext_len, input logic [15:0] n_ch,
                           input logic [15:0] n_bits, input logic [31:0] dsize,
                           input int payload, input bit corrupt);
    logic [31:0] junk_id;
    file_bytes.delete();
    if (with_riff) begin
      push_le(ID_RIFF, 4);
      push_le(pick32(), 4);
      push_le(ID_WAVE, 4);
    end
    if (junk_len >= 0) begin
      do junk_id = $urandom;
      while (junk_id == ID_RIFF || junk_id == ID_FMT || junk_id == ID_DATA);
      push_le(junk_id, 4);
      push_le(junk_len, 4);
      repeat (junk_len) push_le($urandom, 1);
    end
    push_le(ID_FMT, 4);
    push_le(fmt_size, 4);
    push_le(pick32(), 2);
    push_le(n_ch, 2);
    push_le(pick32(), 4);
    push_le(pick32(), 4);
    push_le(pick32(), 2);
    push_le(n_bits, 2);
    if (fmt_size == FMT_SIZE_EXT) begin
      push_le(ext_len, 2);
      repeat (ext_len) push_le($urandom, 1);
    end else if (fmt_size > FMT_SIZE_STD) begin
      repeat (fmt_size - FMT_SIZE_STD) push_le($urandom, 1);
    end
    push_le(ID_DATA, 4);
    push_le(dsize, 4);
    repeat (payload) push_le($urandom, 1);
    if (corrupt) file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom);
    foreach (file_bytes[i]) send_word(file_bytes[i], i == 0);
  endtask

  task automatic test_pcm_depths();
    // 16, 8 and 32-bit depths; the first file has a partial frame and bytes past the data chunk
    send_file(1, -1, 16, 0, 16'd2, 16'd16, 32'd10, 14, 0);
    send_file(0, -1, 16, 0, 16'd1, 16'd8, 32'd4, 4, 0);
    send_file(0, -1, 16, 0, 16'd3, 16'd32, 32'd12, 12, 0);
  endtask

  task automatic test_fmt_sizes();
    send_file(0, -1, 18, 2, 16'd1, 16'd8, 32'd3, 3, 0);
    send_file(0, -1, 18, 0, 16'd2, 16'd8, 32'd2, 2, 0);
    send_file(0, -1, 20, 0, 16'd1, 16'd16, 32'd2, 2, 0);
    send_file(0, -1, 14, 0, 16'd1, 16'd8, 32'd2, 2, 0);
  endtask

  task automatic test_chunk_skip();
    send_file(0, 0, 16, 0, 16'd1, 16'd8, 32'd2, 2, 0);
    send_file(0, 3, 16, 0, 16'd2, 16'd8, 32'd2, 2, 0);
  endtask

  task automatic test_unsupported_layout();
    send_file(0, -1, 16, 0, 16'd1, 16'd24, 32'd6, 6, 0);
    send_file(0, -1, 16, 0, 16'd1, 16'd0, 32'd2, 2, 0);
    send_file(0, -1, 16, 0, 16'd0, 16'd16, 32'd2, 2, 0);
    send_file(0, -1, 16, 0, 16'd2, 16'hFFFF, 32'd2, 2, 0);
  endtask

  task automatic test_empty_data();
    send_file(0, -1, 16, 0, 16'd1, 16'd16, 32'd0, 3, 0);
    send_file(0, -1, 16, 0, 16'hFFFF, 16'd8, 32'd5, 5, 0);
  endtask

  task automatic test_restart();
    send_file(1, -1, 16, 0, 16'd1, 16'd8, 32'hFFFF_FFFF, 6, 0);
    send_file(0, -1, 16, 0, 16'd2, 16'd16, 32'd40, 6, 0);
  endtask

  task automatic test_random_files();
    int payload;
    int n_files;
    logic [15:0] n_ch;
    logic [15:0] n_bits;
    logic [31:0] dsize;
    int fmt_choices[8] = '{16, 16, 16, 18, 18, 20, 14, 17};
    n_files = 0;
    do begin
      case ($urandom_range(0, 9))
        0: n_ch = 16'd0;
        1: n_ch = 16'hFFFF;
        default: n_ch = 16'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 9))
        0: n_bits = 16'($urandom);
        1: n_bits = 16'd24;
        default: n_bits = 16'd8 << $urandom_range(0, 2);
      endcase
      payload = $urandom_range(0, 24);
      case ($urandom_range(0, 3))
        0: dsize = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : payload + $urandom_range(1, 8);
        1: dsize = $urandom_range(0, payload);
        default: dsize = payload;
      endcase
      send_file($urandom_range(0, 4) != 0,
                ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 5)) : -1,
                fmt_choices[$urandom_range(0, 7)], $urandom_range(0, 3),
                n_ch, n_bits, dsize, payload, $urandom_range(0, 7) == 0);
      n_files++;
      if (n_files % 6 == 0) pause_until_drained();
    end while (words_sent < 620);
  endtask

  task automatic test_noise();
    repeat (16) send_word(8'($urandom), $urandom_range(0, 15) == 0);
  endtask

  initial begin
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    byte_value_i      = '0;
    start_of_stream_i = 1'b0;
    mismatch_count    = 0;
    words_sent        = 0;
    burst_left        = 0;
    clear_parser();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_pcm_depths();
    test_fmt_sizes();
    pause_until_drained();
    test_chunk_skip();
    test_unsupported_layout();
    test_empty_data();
    test_restart();
    pause_until_drained();
    test_random_files();
    test_noise();

    pause_until_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
